/* hdl/iwt_pkg.sv */
// ----------------------------------------------------------------------------
// iwt_pkg
// Shared types and constants for the instruction window timing block.
// ----------------------------------------------------------------------------
`default_nettype none

package iwt_pkg;

   // Window geometry
   localparam int WINDOW_DEPTH  = 128;
   localparam int TIME_BITS     = 48;
   localparam int RESET_ENTRIES = 128;

   // Configuration port
   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [TIME_BITS-1:0] time_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_MODE    = 1'b0,
      CSR_WINDOW_ENTRIES = 1'b1
   } csr_index_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic     clear;   // zero the cell
      logic     step;    // insert one item this cycle
      time_type value;   // time being inserted (already clamped)
   } cell_ctl_type;

endpackage

`default_nettype wire

/* hdl/iwt_cell.sv */
// ----------------------------------------------------------------------------
// iwt_cell
// One window entry: holds a ready time, compares it to the inserted time and
// takes its upper neighbor's value, the inserted time, or holds; clear zeroes it.
// ----------------------------------------------------------------------------
`default_nettype none

module iwt_cell (
   input  wire logic                  clock,
   input  wire iwt_pkg::cell_ctl_type ctl,
   input  wire logic                  first,
   input  wire logic                  active,
   input  wire iwt_pkg::time_type     upper_value,
   input  wire logic                  upper_lt,
   output iwt_pkg::time_type          value,
   output logic                       lt
);

   iwt_pkg::time_type value_ff;
   iwt_pkg::time_type value_in;

   // This entry is in use and smaller than the inserted time
   assign lt    = active & (value_ff < ctl.value);
   assign value = value_ff;

   // Shift down below the insert point, take the new time at it, hold above
   always_comb begin
      value_in = value_ff;
      if (ctl.clear) begin
         value_in = '0;
      end else if (ctl.step) begin
         if (upper_lt) begin
            value_in = upper_value;
         end else if (first | lt) begin
            value_in = ctl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

/* hdl/iwt_chain.sv */
// ----------------------------------------------------------------------------
// iwt_chain
// Row of window cells kept in ascending order; cell 0 holds the head.
// ----------------------------------------------------------------------------
`default_nettype none

module iwt_chain (
   input  wire logic                                clock,
   input  wire iwt_pkg::cell_ctl_type               ctl,
   input  wire logic [iwt_pkg::WINDOW_DEPTH-1:0]    active,
   output iwt_pkg::time_type                        head_next
);

   iwt_pkg::time_type cell_value [iwt_pkg::WINDOW_DEPTH+1];
   logic [iwt_pkg::WINDOW_DEPTH:0] cell_lt;

   // Nothing above the last cell
   assign cell_value[iwt_pkg::WINDOW_DEPTH] = '0;
   assign cell_lt[iwt_pkg::WINDOW_DEPTH]    = 1'b0;

   for (genvar i = 0; i < iwt_pkg::WINDOW_DEPTH; i++) begin : g_cell
      iwt_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .first       ((i == 0) ? 1'b1 : 1'b0),
         .active      (active[i]),
         .upper_value (cell_value[i+1]),
         .upper_lt    (cell_lt[i+1]),
         .value       (cell_value[i]),
         .lt          (cell_lt[i])
      );
   end

   // New head: cell 1 shifts down if it is below the new time, else new time
   assign head_next = cell_lt[1] ? cell_value[1] : ctl.value;

endmodule

`default_nettype wire

/* hdl/instruction_window_timing.sv */
// ----------------------------------------------------------------------------
// instruction_window_timing
// Sorted window of instruction ready times: reports head and running tail.
// ----------------------------------------------------------------------------
// Takes one item per clock: busy stays low, so start may be held high every
// cycle. Each item gives one result on rsp_valid: the input register takes
// the item, and the result register takes the insert across the cell row.
// Every window cell compares itself to the inserted time in the same cycle,
// so the rate does not depend on the window size. The receiver cannot
// stall: rsp_valid is a one-cycle strobe and the result must be taken then.
// A write to either register clears the window and the tail at the write
// edge. Write only while no item is in flight, since a clear in the same
// cycle as an insert wins over it.
// ----------------------------------------------------------------------------
`default_nettype none

module instruction_window_timing (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [iwt_pkg::TIME_BITS-1:0]        req_ready_time,
   output logic                                      rsp_valid,
   output logic [iwt_pkg::TIME_BITS-1:0]             rsp_head_time,
   output logic [iwt_pkg::TIME_BITS-1:0]             rsp_tail_time,
   input  wire logic                                 csr_write_en,
   input  wire logic [iwt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [iwt_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic                              mode_ff, mode_in;
   logic [iwt_pkg::WINDOW_DEPTH-1:0]  active_ff, active_in;
   logic                              req_vld_ff;
   iwt_pkg::time_type                 req_time_ff;
   iwt_pkg::time_type                 tail_ff, tail_in;
   logic                              rsp_vld_ff;
   iwt_pkg::time_type                 rsp_head_ff;
   iwt_pkg::time_type                 rsp_tail_ff;
   iwt_pkg::time_type                 ins_time;
   iwt_pkg::time_type                 head_next;
   iwt_pkg::cell_ctl_type             ctl;
   logic                              csr_clear;

   assign busy = 1'b0;

   // Register writes
   always_comb begin
      mode_in   = mode_ff;
      active_in = active_ff;
      csr_clear = 1'b0;
      if (csr_write_en) begin
         unique case (iwt_pkg::csr_index_type'(csr_index))
            iwt_pkg::CSR_WINDOW_MODE: begin
               mode_in   = csr_wdata[0];
               csr_clear = 1'b1;
            end
            iwt_pkg::CSR_WINDOW_ENTRIES: begin
               // Zero entries acts as one; counts past the depth saturate
               for (int i = 0; i < iwt_pkg::WINDOW_DEPTH; i++) begin
                  active_in[i] = (i == 0) || (i < int'(csr_wdata));
               end
               csr_clear = 1'b1;
            end
            default: begin
               csr_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         for (int i = 0; i < iwt_pkg::WINDOW_DEPTH; i++) begin
            active_ff[i] <= (i == 0) || (i < iwt_pkg::RESET_ENTRIES);
         end
      end else begin
         mode_ff   <= mode_in;
         active_ff <= active_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start & ~busy;
      end
      req_time_ff <= req_ready_time;
   end

   // Reorder-buffer mode raises the new time to the tail
   assign ins_time = (mode_ff && (req_time_ff < tail_ff)) ? tail_ff : req_time_ff;

   assign ctl.clear = reset | csr_clear;
   assign ctl.step  = req_vld_ff;
   assign ctl.value = ins_time;

   iwt_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .active    (active_ff),
      .head_next (head_next)
   );

   // Running maximum
   always_comb begin
      tail_in = tail_ff;
      if (ctl.clear) begin
         tail_in = '0;
      end else if (req_vld_ff && (ins_time > tail_ff)) begin
         tail_in = ins_time;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
      if (req_vld_ff) begin
         rsp_head_ff <= head_next;
         rsp_tail_ff <= tail_in;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_head_time = rsp_head_ff;
   assign rsp_tail_time = rsp_tail_ff;

`ifndef SYNTHESIS
   // One result per accepted item, from the result register
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_vld_ff |=> rsp_valid)
      else $error("item result missing");

   // Head never exceeds tail
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_time <= rsp_tail_time))
      else $error("head above tail");

   // Tail only grows between clears
   a_tail_mono: assert property (@(posedge clock) disable iff (reset)
      !ctl.clear |=> (tail_ff >= $past(tail_ff)))
      else $error("tail decreased");

   // Reorder mode: the inserted time is never below the tail
   a_rob_clamp: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && mode_ff) |-> (ins_time >= tail_ff))
      else $error("reorder insert below tail");
`endif

endmodule

`default_nettype wire
